// ===== rtl/tcpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_pkg
// Shared types and constants of the text cell pixel compositor.
// ----------------------------------------------------------------------------
package tcpc_pkg;

    // Attribute bit positions within the low byte of a colour word.
    localparam int unsigned BOLD_BIT      = 0;
    localparam int unsigned FAINT_BIT     = 1;
    localparam int unsigned UNDERLINE_BIT = 3;
    localparam int unsigned REVERSE_BIT   = 5;
    localparam int unsigned INVISIBLE_BIT = 6;
    localparam int unsigned STRUCK_BIT    = 7;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROW_W    = 8;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned STAGES   = 5;

    // Stream widths: payload bits padded to whole bytes.
    localparam int unsigned IN_BITS    = 4 * WORD_W + 2 + CHAN_W + ROW_W;
    localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W = NUM_CHAN * CHAN_W;

    // Configuration register indexes.
    localparam logic CFG_CELL_HEIGHT = 1'b0;
    localparam logic CFG_DEFAULT_BG  = 1'b1;

    // Reset values of the configuration.
    localparam int unsigned CELL_HEIGHT_RESET = 16;
    localparam logic [7:0]  UL_ROW_RESET = 8'(CELL_HEIGHT_RESET * 86 / 100);
    localparam logic [6:0]  HALF_RESET   = 7'(CELL_HEIGHT_RESET / 2);
    localparam logic [CFG_W-1:0] DEFAULT_BG_RESET = '0;

    // floor(h * 86 / 100) as (h * UL_RECIP) >> UL_SHIFT, exact for 8-bit h.
    localparam logic [18:0] UL_RECIP = 19'd450898;
    localparam int unsigned UL_SHIFT = 19;

    // floor(f * 3 / 5) as (f * FAINT_MUL) >> FAINT_SHIFT, exact for 8-bit f.
    localparam logic [9:0]  FAINT_MUL   = 10'd615;
    localparam int unsigned FAINT_SHIFT = 10;

    // floor(x / 255) as (x * DIV255_MUL) >> DIV255_SHIFT, exact for x <= 255*255.
    localparam logic [15:0] DIV255_MUL   = 16'd32897;
    localparam int unsigned DIV255_SHIFT = 23;

    localparam logic [7:0] BOLD_ADD = 8'd30;
    localparam logic [7:0] CHAN_MAX = 8'hff;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

    // One input beat, unpacked.
    typedef struct packed {
        logic [WORD_W-1:0] cursor_back;
        logic [WORD_W-1:0] cursor_fore;
        logic              cursor_cell;
        logic [ROW_W-1:0]  pixel_row;
        logic [CHAN_W-1:0] coverage;
        logic              has_char;
        logic [WORD_W-1:0] back_word;
        logic [WORD_W-1:0] fore_word;
    } pix_in_t;

    // Resolved colours and coverage after the first stage.
    typedef struct packed {
        rgb_t              fg;
        rgb_t              bg;
        logic              faint;
        logic [CHAN_W-1:0] cov;
        logic              empty;
    } sel_t;

    // Derived configuration handed to the datapath.
    typedef struct packed {
        logic [7:0]        ul_row;
        logic [6:0]        half;
        logic [CFG_W-1:0]  default_bg;
    } cfg_t;

endpackage

// ===== rtl/tcpc_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_select
// First stage: colour choice, attributes and underline/strike coverage.
// ----------------------------------------------------------------------------
module tcpc_select (
    input  logic             clk,
    input  logic             en,
    input  tcpc_pkg::pix_in_t pix,
    input  tcpc_pkg::cfg_t   cfg,
    output tcpc_pkg::sel_t   sel
);

    tcpc_pkg::sel_t sel_reg;
    tcpc_pkg::sel_t sel_next;

    always_comb
    begin
        logic [31:0] fore;
        logic [31:0] back;
        logic [7:0]  attr;
        logic [7:0]  f;
        logic [7:0]  b;
        logic [8:0]  f_sum;
        logic        ul_hit;
        logic        st_hit;

        fore = pix.fore_word;
        back = pix.back_word;
        if (pix.cursor_cell)
        begin
            if (pix.has_char)
            begin
                fore = pix.back_word;
                back = pix.fore_word;
            end
            else
            begin
                fore = pix.cursor_back;
                back = pix.cursor_fore;
            end
        end
        attr = fore[7:0];

        for (int i = 0; i < tcpc_pkg::NUM_CHAN; i++)
        begin
            f = fore[31 - 8 * i -: 8];
            b = back[31 - 8 * i -: 8];
            f_sum = 9'd0;
            if (attr[tcpc_pkg::REVERSE_BIT])
            begin
                f = back[31 - 8 * i -: 8];
                b = fore[31 - 8 * i -: 8];
            end
            if (attr[tcpc_pkg::INVISIBLE_BIT])
                f = b;
            if (attr[tcpc_pkg::BOLD_BIT])
            begin
                f_sum = {1'b0, f} + {1'b0, tcpc_pkg::BOLD_ADD};
                f = f_sum[8] ? tcpc_pkg::CHAN_MAX : f_sum[7:0];
            end
            sel_next.fg[i] = f;
            sel_next.bg[i] = b;
        end

        ul_hit = attr[tcpc_pkg::UNDERLINE_BIT] && (pix.pixel_row >= cfg.ul_row);
        st_hit = attr[tcpc_pkg::STRUCK_BIT]
                 && (({1'b0, pix.pixel_row} + 9'd1) >= {2'b00, cfg.half})
                 && ({1'b0, pix.pixel_row} <= ({2'b00, cfg.half} + 9'd1));

        sel_next.faint = attr[tcpc_pkg::FAINT_BIT];
        sel_next.cov   = (ul_hit || st_hit) ? tcpc_pkg::CHAN_MAX : pix.coverage;
        sel_next.empty = !pix.has_char && (pix.fore_word == '0)
                         && (pix.back_word == '0) && !pix.cursor_cell;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sel_reg <= sel_next;
    end

    assign sel = sel_reg;

endmodule

// ===== rtl/tcpc_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_blend
// Four stages: faint scaling, blend products, sum, divide by 255 and
// default background selection.
// ----------------------------------------------------------------------------
module tcpc_blend (
    input  logic                              clk,
    input  logic [3:0]                        en,
    input  tcpc_pkg::sel_t                    sel,
    input  logic [tcpc_pkg::CFG_W-1:0]        default_bg,
    output tcpc_pkg::rgb_t                    rgb
);

    // Stage 2: faint applied, inverse coverage.
    tcpc_pkg::rgb_t fg2_reg, fg2_next;
    tcpc_pkg::rgb_t bg2_reg;
    logic [7:0]     cov2_reg;
    logic [7:0]     icov2_reg;
    logic           empty2_reg;

    // Stage 3: products.
    logic [2:0][15:0] pf3_reg, pf3_next;
    logic [2:0][15:0] pb3_reg, pb3_next;
    logic             empty3_reg;

    // Stage 4: blended sum.
    logic [2:0][15:0] sum4_reg, sum4_next;
    logic             empty4_reg;

    // Stage 5: quotient or default background.
    tcpc_pkg::rgb_t rgb5_reg, rgb5_next;

    always_comb
    begin
        logic [17:0] prod;
        for (int i = 0; i < tcpc_pkg::NUM_CHAN; i++)
        begin
            prod = sel.fg[i] * tcpc_pkg::FAINT_MUL;
            fg2_next[i] = sel.faint ? prod[tcpc_pkg::FAINT_SHIFT +: 8] : sel.fg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < tcpc_pkg::NUM_CHAN; i++)
        begin
            pf3_next[i] = fg2_reg[i] * cov2_reg;
            pb3_next[i] = bg2_reg[i] * icov2_reg;
            sum4_next[i] = pf3_reg[i] + pb3_reg[i];
        end
    end

    always_comb
    begin
        logic [31:0] q;
        for (int i = 0; i < tcpc_pkg::NUM_CHAN; i++)
        begin
            q = sum4_reg[i] * tcpc_pkg::DIV255_MUL;
            rgb5_next[i] = empty4_reg ? default_bg[23 - 8 * i -: 8]
                                      : q[tcpc_pkg::DIV255_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fg2_reg    <= fg2_next;
            bg2_reg    <= sel.bg;
            cov2_reg   <= sel.cov;
            icov2_reg  <= tcpc_pkg::CHAN_MAX - sel.cov;
            empty2_reg <= sel.empty;
        end
        if (en[1])
        begin
            pf3_reg    <= pf3_next;
            pb3_reg    <= pb3_next;
            empty3_reg <= empty2_reg;
        end
        if (en[2])
        begin
            sum4_reg   <= sum4_next;
            empty4_reg <= empty3_reg;
        end
        if (en[3])
            rgb5_reg <= rgb5_next;
    end

    assign rgb = rgb5_reg;

endmodule

// ===== rtl/text_cell_pixel_compositor_top.sv =====
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while m_tready is held high; a beat passes
// five register stages in turn (select, faint, products, sum, quotient), each of
// which takes a new beat whenever the stage after it is empty or moving on.
// Reset: rst_n clears every stage valid bit and restores the configuration
// (cell height 16, default background black); payload registers are not reset.
// ----------------------------------------------------------------------------
// text_cell_pixel_compositor_top
// Gives the RGB value of one pixel of a terminal character cell.
// ----------------------------------------------------------------------------
module text_cell_pixel_compositor_top (
    input  logic                                clk,
    input  logic                                rst_n,

    // Input stream. s_tdata, from bit 0 up: fore_word[31:0], back_word[63:32],
    // has_char[64], coverage[72:65], pixel_row[80:73], cursor_cell[81],
    // cursor_fore[113:82], cursor_back[145:114], zero padding[151:146].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tcpc_pkg::IN_TDATA_W-1:0]     s_tdata,

    // Output stream. m_tdata, from bit 0 up: red[7:0], green[15:8], blue[23:16].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tcpc_pkg::OUT_TDATA_W-1:0]    m_tdata,

    // Configuration write port. Index 0 is the cell height in pixels, index 1
    // is the default background (red 23:16, green 15:8, blue 7:0).
    input  logic                                cfg_wen,
    input  logic                                cfg_addr,
    input  logic [tcpc_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int unsigned NS = tcpc_pkg::STAGES;

    // The configuration is kept in the form the datapath needs: the first
    // underline row and half the cell height are worked out when written.
    logic [7:0]                  ul_row_reg, ul_row_next;
    logic [6:0]                  half_reg, half_next;
    logic [tcpc_pkg::CFG_W-1:0]  dbg_reg, dbg_next;
    tcpc_pkg::cfg_t              cfg;

    // One valid bit per stage; stage NS-1 is the output register.
    logic [NS-1:0] v_reg, v_next;
    logic [NS-1:0] en;

    tcpc_pkg::pix_in_t pix;
    tcpc_pkg::sel_t    sel;
    tcpc_pkg::rgb_t    rgb;

    always_comb
    begin
        logic [26:0] ul_prod;
        ul_row_next = ul_row_reg;
        half_next   = half_reg;
        dbg_next    = dbg_reg;
        ul_prod     = cfg_wdata[7:0] * tcpc_pkg::UL_RECIP;
        if (cfg_wen)
        begin
            case (cfg_addr)
                tcpc_pkg::CFG_CELL_HEIGHT:
                begin
                    ul_row_next = ul_prod[tcpc_pkg::UL_SHIFT +: 8];
                    half_next   = cfg_wdata[7:1];
                end
                tcpc_pkg::CFG_DEFAULT_BG:
                    dbg_next = cfg_wdata;
                default:
                    dbg_next = dbg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_row_reg <= tcpc_pkg::UL_ROW_RESET;
            half_reg   <= tcpc_pkg::HALF_RESET;
            dbg_reg    <= tcpc_pkg::DEFAULT_BG_RESET;
        end
        else
        begin
            ul_row_reg <= ul_row_next;
            half_reg   <= half_next;
            dbg_reg    <= dbg_next;
        end
    end

    assign cfg.ul_row     = ul_row_reg;
    assign cfg.half       = half_reg;
    assign cfg.default_bg = dbg_reg;

    // A stage loads when it is empty or when the stage after it loads, so
    // bubbles close up and a stall holds every occupied stage in place.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];

        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NS; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    assign pix = s_tdata[tcpc_pkg::IN_BITS-1:0];

    tcpc_select u_select (
        .clk (clk),
        .en  (en[0]),
        .pix (pix),
        .cfg (cfg),
        .sel (sel)
    );

    tcpc_blend u_blend (
        .clk        (clk),
        .en         (en[NS-1:1]),
        .sel        (sel),
        .default_bg (dbg_reg),
        .rgb        (rgb)
    );

    // Channel 0 is red, which goes to the lowest byte.
    assign m_tdata = {rgb[2], rgb[1], rgb[0]};

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted beat did not enter the first stage");

    // Beats in flight are conserved: one in and none out adds exactly one.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
        |=> ($countones(v_reg) == $countones($past(v_reg)) + 1))
        else $error("beat count in the pipeline went wrong");

    // A held stage keeps its beat.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(v_reg) & ~$past(en) & ~v_reg) == '0))
        else $error("a stalled stage dropped its beat");

    // With the output register empty the pipeline can always take a beat.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled although the output register is empty");

endmodule

// ===== tb/tcpc_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpc_pixel_checker
// Watches the pixel streams and the register port of the compositor, works
// out the colour of every accepted pixel and compares it with the output.
// ----------------------------------------------------------------------------
module tcpc_pixel_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [tcpc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tcpc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_wen,
    input  logic                             cfg_addr,
    input  logic [tcpc_pkg::CFG_W-1:0]       cfg_wdata,
    output int                               errors,
    output int                               pending
);

    // Same layout as m_tdata: red in the low byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_rgb_t;

    logic [7:0]                 cell_h;
    logic [tcpc_pkg::CFG_W-1:0] screen_bg;
    pixel_rgb_t                 expected_pixels[$];

    task automatic report_fault(input string what, input logic [23:0] want,
                                input logic [23:0] got);
        $display("%0t pixel check: %s, expected %0h, got %0h", $realtime, what,
                 want, got);
        errors++;
    endtask

    function automatic pixel_rgb_t shade_pixel(input tcpc_pkg::pix_in_t px);
        logic [tcpc_pkg::WORD_W-1:0] fg_word;
        logic [tcpc_pkg::WORD_W-1:0] bg_word;
        logic [7:0]                  attr;
        int unsigned                 fg [tcpc_pkg::NUM_CHAN];
        int unsigned                 bg [tcpc_pkg::NUM_CHAN];
        int unsigned                 mixed [tcpc_pkg::NUM_CHAN];
        int unsigned                 swap;
        int unsigned                 cov;
        int unsigned                 row;
        int unsigned                 half;
        pixel_rgb_t                  pix;

        if (!px.has_char && px.fore_word == '0 && px.back_word == '0
            && !px.cursor_cell)
        begin
            pix.red   = screen_bg[23:16];
            pix.green = screen_bg[15:8];
            pix.blue  = screen_bg[7:0];
            return pix;
        end

        fg_word = px.fore_word;
        bg_word = px.back_word;
        if (px.cursor_cell)
        begin
            fg_word = px.has_char ? px.back_word : px.cursor_back;
            bg_word = px.has_char ? px.fore_word : px.cursor_fore;
        end
        attr = fg_word[7:0];

        for (int i = 0; i < tcpc_pkg::NUM_CHAN; i++)
        begin
            fg[i] = 32'(fg_word[31 - 8 * i -: 8]);
            bg[i] = 32'(bg_word[31 - 8 * i -: 8]);
            if (attr[tcpc_pkg::REVERSE_BIT])
            begin
                swap  = fg[i];
                fg[i] = bg[i];
                bg[i] = swap;
            end
            if (attr[tcpc_pkg::INVISIBLE_BIT])
                fg[i] = bg[i];
            if (attr[tcpc_pkg::BOLD_BIT])
                fg[i] = (fg[i] + 30 > 255) ? 255 : fg[i] + 30;
            if (attr[tcpc_pkg::FAINT_BIT])
                fg[i] = fg[i] * 3 / 5;
        end

        // Underline and strike-through rows paint the whole pixel.
        cov  = 32'(px.coverage);
        row  = 32'(px.pixel_row);
        half = 32'(cell_h) / 2;
        if ((attr[tcpc_pkg::UNDERLINE_BIT] && row >= 32'(cell_h) * 86 / 100) ||
            (attr[tcpc_pkg::STRUCK_BIT] && row + 1 >= half && row <= half + 1))
            cov = 255;

        for (int i = 0; i < tcpc_pkg::NUM_CHAN; i++)
            mixed[i] = ((bg[i] * (255 - cov) + fg[i] * cov) / 255) & 8'hff;
        pix.red   = mixed[0][7:0];
        pix.green = mixed[1][7:0];
        pix.blue  = mixed[2][7:0];
        return pix;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_rgb_t want;
        pixel_rgb_t got;
        if (!rst_n)
        begin
            errors    = 0;
            cell_h    = 8'(tcpc_pkg::CELL_HEIGHT_RESET);
            screen_bg = tcpc_pkg::DEFAULT_BG_RESET;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_addr == tcpc_pkg::CFG_CELL_HEIGHT)
                    cell_h = cfg_wdata[7:0];
                else if (cfg_addr == tcpc_pkg::CFG_DEFAULT_BG)
                    screen_bg = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_pixels.push_back(shade_pixel(
                    tcpc_pkg::pix_in_t'(s_tdata[$bits(tcpc_pkg::pix_in_t)-1:0])));
            if (m_tvalid && m_tready)
            begin
                got = pixel_rgb_t'(m_tdata);
                if (expected_pixels.size() == 0)
                begin
                    report_fault("pixel with nothing expected", 24'h0, got);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red != want.red)
                        report_fault("red", 24'(want.red), 24'(got.red));
                    if (got.green != want.green)
                        report_fault("green", 24'(want.green), 24'(got.green));
                    if (got.blue != want.blue)
                        report_fault("blue", 24'(want.blue), 24'(got.blue));
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the text cell pixel compositor.
// A short directed run covers empty cells, the cursor, every attribute and the
// underline and strike rows; random pixels then run under several register
// settings with random gaps and stalls on both streams. The checker beside the
// block predicts every pixel and counts mismatches.
// ----------------------------------------------------------------------------
module tb;

    // Generous bound on the whole run, in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_BEATS = 200;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [tcpc_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [tcpc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_wen   = 1'b0;
    logic                             cfg_addr  = tcpc_pkg::CFG_CELL_HEIGHT;
    logic [tcpc_pkg::CFG_W-1:0]       cfg_wdata = '0;

    int          errors;
    int          pending;
    int unsigned cycles = 0;

    // While calm, the sender puts out back-to-back beats.
    bit sender_calm = 1'b0;

    always #5 clk = ~clk;

    text_cell_pixel_compositor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    tcpc_pixel_checker pixel_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // The run must end well before this; a hang anywhere lands here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Most gaps are short, a few are long, and calm stretches have none.
    function automatic int unsigned idle_cycles(input bit calm);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: the receiver stalls in random windows, changing at the
    // falling edge so the block sees a settled m_tready at the rising edge.
    int unsigned stall_left = 0;
    int unsigned window_left = 0;
    bit          receiver_calm = 1'b0;

    always @(negedge clk)
    begin
        if (window_left == 0)
        begin
            window_left   = $urandom_range(20, 200);
            receiver_calm = ($urandom_range(0, 2) == 0);
        end
        window_left--;
        if (stall_left == 0)
            stall_left = idle_cycles(receiver_calm);
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic tcpc_pkg::pix_in_t make_pixel(input logic [31:0] fore,
                                                     input logic [31:0] back,
                                                     input logic has_char,
                                                     input logic [7:0] cov,
                                                     input logic [7:0] row,
                                                     input logic cursor_cell,
                                                     input logic [31:0] cur_fore,
                                                     input logic [31:0] cur_back);
        tcpc_pkg::pix_in_t px;
        px.fore_word   = fore;
        px.back_word   = back;
        px.has_char    = has_char;
        px.coverage    = cov;
        px.pixel_row   = row;
        px.cursor_cell = cursor_cell;
        px.cursor_fore = cur_fore;
        px.cursor_back = cur_back;
        return px;
    endfunction

    // Rows are biased toward the strike band and the inside of the cell, so
    // that underline and strike rows come up often at every height.
    function automatic logic [7:0] pick_row(input int unsigned height);
        int unsigned half;
        int unsigned sel;
        int unsigned top;
        half = height / 2;
        sel  = $urandom_range(0, 2);
        if (sel == 0)
        begin
            top = (half + 2 > 254) ? 254 : half + 2;
            return 8'($urandom_range((half > 2) ? half - 2 : 0, top));
        end
        if (sel == 1)
        begin
            top = (height == 0) ? 0 : height - 1;
            return 8'($urandom_range(0, (top > 254) ? 254 : top));
        end
        return 8'($urandom_range(0, 254));
    endfunction

    function automatic tcpc_pkg::pix_in_t random_pixel(input int unsigned height);
        tcpc_pkg::pix_in_t px;
        int unsigned       kind;
        int unsigned       cov_pick;
        kind     = $urandom_range(0, 99);
        cov_pick = $urandom_range(0, 3);
        px = make_pixel($urandom(), $urandom(), ($urandom_range(0, 3) != 0), 8'($urandom()),
                        pick_row(height), ($urandom_range(0, 3) == 0), $urandom(), $urandom());
        if (cov_pick == 0)
            px.coverage = 8'h00;
        else if (cov_pick == 1)
            px.coverage = 8'hff;
        if (kind < 12)
        begin
            // Empty cell: shows the screen background.
            px.fore_word   = '0;
            px.back_word   = '0;
            px.has_char    = 1'b0;
            px.cursor_cell = 1'b0;
        end
        else if (kind < 20)
        begin
            // Nearly empty: one thing keeps it from being blank.
            px.fore_word   = '0;
            px.back_word   = (kind < 16) ? 32'h0 : px.back_word;
            px.has_char    = 1'b0;
            px.cursor_cell = (kind < 16);
        end
        else if (kind < 26)
        begin
            px.back_word = '0;
        end
        return px;
    endfunction

    // One input beat: raise valid at the falling edge, hold until accepted,
    // then maybe drop valid for a gap.
    task automatic send_pixel(input tcpc_pkg::pix_in_t px);
        int unsigned gap;
        s_tdata  = tcpc_pkg::IN_TDATA_W'(px);
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        gap = idle_cycles(sender_calm);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold the input until every predicted pixel has come out, then let the
    // pipeline settle before touching the registers.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [tcpc_pkg::CFG_W-1:0] value);
        cfg_addr  = index;
        cfg_wdata = value;
        cfg_wen   = 1'b1;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    initial
    begin
        int unsigned                height;
        logic [tcpc_pkg::CFG_W-1:0] screen_bg;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed beats at the reset settings: cell height 16, so the
        // underline starts at row 13 and strike covers rows 7 to 9.
        sender_calm = 1'b0;
        send_pixel(make_pixel(32'h0, 32'h0, 1'b0, 8'h00, 8'd0, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'h0, 32'h0, 1'b0, 8'hff, 8'd15, 1'b0, '1, '1));
        send_pixel(make_pixel(32'hffffff00, 32'h0, 1'b1, 8'hff, 8'd0, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffffff00, 32'h0, 1'b1, 8'h00, 8'd0, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'h80ff2000, 32'h20408000, 1'b1, 8'h80, 8'd3, 1'b0,
                              32'h0, 32'h0));
        // Bold saturates, faint scales, and both together.
        send_pixel(make_pixel(32'hf0e11e01, 32'h0, 1'b1, 8'hff, 8'd0, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffff0502, 32'h0, 1'b1, 8'hff, 8'd0, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hfff00a03, 32'h0, 1'b1, 8'hff, 8'd0, 1'b0, 32'h0, 32'h0));
        // Reverse, invisible, and reverse with invisible.
        send_pixel(make_pixel(32'hc0804020, 32'h10203000, 1'b1, 8'h40, 8'd0, 1'b0,
                              32'h0, 32'h0));
        send_pixel(make_pixel(32'hc0804040, 32'h10203000, 1'b1, 8'hff, 8'd0, 1'b0,
                              32'h0, 32'h0));
        send_pixel(make_pixel(32'hc0804061, 32'h10203000, 1'b1, 8'h00, 8'd0, 1'b0,
                              32'h0, 32'h0));
        // Underline: first underline row, the row above it, a row past the cell.
        send_pixel(make_pixel(32'hffffff08, 32'h0, 1'b1, 8'h00, 8'd13, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffffff08, 32'h0, 1'b1, 8'h00, 8'd12, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffffff88, 32'h0, 1'b1, 8'h00, 8'd254, 1'b0, 32'h0, 32'h0));
        // Strike band edges.
        send_pixel(make_pixel(32'hffffff80, 32'h0, 1'b1, 8'h00, 8'd6, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffffff80, 32'h0, 1'b1, 8'h00, 8'd7, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffffff80, 32'h0, 1'b1, 8'h00, 8'd9, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel(32'hffffff80, 32'h0, 1'b1, 8'h00, 8'd10, 1'b0, 32'h0, 32'h0));
        // Cursor with a character swaps the words; a blank cursor cell uses
        // the cursor colours, even when every word is zero.
        send_pixel(make_pixel(32'h11223300, 32'hddeeff00, 1'b1, 8'hc0, 8'd2, 1'b1, '1, '1));
        send_pixel(make_pixel(32'h11223300, 32'hddeeff00, 1'b0, 8'h40, 8'd2, 1'b1,
                              32'h55667700, 32'h99aabb01));
        send_pixel(make_pixel(32'h0, 32'h0, 1'b0, 8'h00, 8'd0, 1'b1, 32'h0, 32'h0));
        // A colour word alone makes the cell non-empty.
        send_pixel(make_pixel(32'h0, 32'h00000100, 1'b0, 8'h00, 8'd0, 1'b0, 32'h0, 32'h0));
        send_pixel(make_pixel('1, '1, 1'b1, 8'hff, 8'd254, 1'b1, '1, '1));

        // Random phases, each under its own register settings, from the
        // extremes of both registers to random ones.
        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            screen_bg = tcpc_pkg::CFG_W'($urandom());
            case (ph)
                0:
                begin
                    height    = 255;
                    screen_bg = '1;
                end
                1:
                begin
                    height    = 1;
                    screen_bg = '0;
                end
                2: height = 0;
                3: height = $urandom_range(2, 40);
                4: height = $urandom_range(1, 255);
                default: height = 16;
            endcase
            write_reg(tcpc_pkg::CFG_CELL_HEIGHT, tcpc_pkg::CFG_W'(height));
            write_reg(tcpc_pkg::CFG_DEFAULT_BG, screen_bg);
            for (int unsigned n = 0; n < PHASE_BEATS; n++)
            begin
                if (n % 50 == 0)
                    sender_calm = ($urandom_range(0, 2) == 0);
                send_pixel(random_pixel(height));
            end
        end

        wait_drained();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcpc_pkg.sv
rtl/tcpc_select.sv
rtl/tcpc_blend.sv
rtl/text_cell_pixel_compositor_top.sv
tb/tcpc_pixel_checker.sv
tb/tb.sv
